>>> rtl/two_way_clock_offset_sync_assert.svh
// assertion macros shared by the rtl modules
`ifndef TWO_WAY_CLOCK_OFFSET_SYNC_ASSERT_SVH
`define TWO_WAY_CLOCK_OFFSET_SYNC_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked outside reset
`define TWCOS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// checked on every edge, reset included
`define TWCOS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define TWCOS_ASSERT(lbl, prop)
`define TWCOS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> rtl/twcos_pkg.sv
// package: types and constants of the two-way clock offset synchronizer
package twcos_pkg;

  localparam int unsigned TIME_W   = 64;
  localparam int unsigned NODE_W   = 8;
  localparam int unsigned GAP_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W    = 32;

  localparam logic [GAP_W-1:0]  MAX_GAP_RST     = 32'd2000000;
  localparam logic [NODE_W-1:0] SERVER_NODE_RST = 8'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_NODE = 1'b1;

  typedef enum logic {
    CMD_SEND = 1'b0,
    CMD_RECV = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [NODE_W-1:0] src_node;
    logic [TIME_W-1:0] remote_time;
    logic [TIME_W-1:0] local_now;
  } item_t;

  // operands for the correction datapath, zero when no correction
  typedef struct packed {
    logic              adjust;
    logic [TIME_W-1:0] d1;
    logic [TIME_W-1:0] d2;
    logic [TIME_W-1:0] nd;
  } xres_t;

endpackage

>>> rtl/two_way_clock_offset_sync.sv
// top level: stream ports, input register and correction pipeline
//
// channel  | dir | fields (low bit first)
// s_*      | in  | tuser: cmd ; tdata: src_node, remote_time, local_now
// m_*      | out | tuser: adjust_valid ; tdata: corrected_time, clock_offset
// cfg_*    | in  | index 0 max_gap, index 1 server_node
//
// one transaction per cycle in and out while m_tready is high; an item passes item0, st1, stage 2 and stage 3
// the stamp state updates as an item leaves the input register
// each stage holds its item while the next one is full and held, bubbles close up
// rst clears the stage valid bits, the stamp valid bits and last_remote, and loads the cfg reset values
`include "two_way_clock_offset_sync_assert.svh"
module two_way_clock_offset_sync
  import twcos_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [135:0]         s_tdata,   // src_node, remote_time, local_now
  input  logic                 s_tuser,   // cmd
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [127:0]         m_tdata,   // corrected_time, clock_offset
  output logic                 m_tuser,   // adjust_valid
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  item_t             item0;
  logic              v0, v1, v2, v3;
  logic              rdy1, rdy2, rdy3;
  xres_t             xres;
  xres_t             st1;
  logic              adj2;
  logic [TIME_W-1:0] pd2, d1_2, nd2;
  logic              adj3;
  logic [TIME_W-1:0] offset3, corr3;
  logic [TIME_W:0]   sum1;

  assign rdy3     = !v3 || m_tready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = !v0 || rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (s_tready) v0 <= s_tvalid;
      if (rdy1)     v1 <= v0;
      if (rdy2)     v2 <= v1;
      if (rdy3)     v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item0.cmd         <= cmd_t'(s_tuser);
      item0.src_node    <= s_tdata[7:0];
      item0.remote_time <= s_tdata[71:8];
      item0.local_now   <= s_tdata[135:72];
    end
  end

  twcos_exchange u_exchange (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .step      (v0 && rdy1),
    .item      (item0),
    .res       (xres)
  );

  always_ff @(posedge clk) begin
    if (rdy1 && v0) st1 <= xres;
  end

  assign sum1 = {1'b0, st1.d1} + {1'b0, st1.d2};

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      adj2 <= st1.adjust;
      pd2  <= {1'b0, sum1[TIME_W-1:1]};
      d1_2 <= st1.d1;
      nd2  <= st1.nd;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      adj3    <= adj2;
      offset3 <= d1_2 - pd2;
      corr3   <= nd2 + pd2;
    end
  end

  assign m_tvalid = v3;
  assign m_tuser  = adj3;
  assign m_tdata  = {offset3, corr3};

  `TWCOS_ASSERT(a_no_adjust_zero, m_tvalid && !m_tuser |-> m_tdata == '0)
  `TWCOS_ASSERT_ALWAYS(a_empty_input_ready, !v0 |-> s_tready)
  `TWCOS_ASSERT(a_drain, v3 && m_tready && !v2 |=> !v3)

endmodule

>>> rtl/twcos_exchange.sv
// stamp state, gap check and configuration registers of the exchange
`include "two_way_clock_offset_sync_assert.svh"
module twcos_exchange
  import twcos_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 step,
  input  item_t                item,
  output xres_t                res
);

  logic [GAP_W-1:0]  max_gap;
  logic [NODE_W-1:0] server_node;
  logic [TIME_W-1:0] d1, d1_next;
  logic [TIME_W-1:0] send_local, send_local_next;
  logic [TIME_W-1:0] last_remote, last_remote_next;
  logic              pair_valid, pair_valid_next;
  logic              send_valid, send_valid_next;
  logic              gap_ok;
  logic              is_server;
  logic              adjust;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_gap     <= MAX_GAP_RST;
      server_node <= SERVER_NODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAX_GAP:     max_gap     <= cfg_wdata[GAP_W-1:0];
        CFG_SERVER_NODE: server_node <= cfg_wdata[NODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign gap_ok    = (item.remote_time - last_remote) < {{(TIME_W-GAP_W){1'b0}}, max_gap};
  assign is_server = (item.cmd == CMD_RECV) && (item.src_node == server_node);
  assign adjust    = is_server && gap_ok && pair_valid && send_valid;

  always_comb begin
    d1_next          = d1;
    send_local_next  = send_local;
    last_remote_next = last_remote;
    pair_valid_next  = pair_valid;
    send_valid_next  = send_valid;
    if (step) begin
      if (item.cmd == CMD_SEND) begin
        if (pair_valid && !send_valid) begin
          send_local_next = item.local_now;
          send_valid_next = 1'b1;
        end
      end else if (is_server) begin
        last_remote_next = item.remote_time;
        if (gap_ok) begin
          if (!pair_valid) begin
            d1_next         = item.local_now - item.remote_time;
            pair_valid_next = 1'b1;
          end else if (send_valid) begin
            pair_valid_next = 1'b0;
            send_valid_next = 1'b0;
          end
        end else begin
          pair_valid_next = 1'b0;
          send_valid_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_remote <= '0;
      pair_valid  <= 1'b0;
      send_valid  <= 1'b0;
    end else begin
      last_remote <= last_remote_next;
      pair_valid  <= pair_valid_next;
      send_valid  <= send_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    d1         <= d1_next;
    send_local <= send_local_next;
  end

  always_comb begin
    res.adjust = adjust;
    res.d1     = adjust ? d1 : '0;
    res.d2     = adjust ? (item.remote_time - send_local) : '0;
    res.nd     = adjust ? (item.local_now - d1) : '0;
  end

  `TWCOS_ASSERT_ALWAYS(a_send_needs_pair, send_valid |-> pair_valid)
  `TWCOS_ASSERT(a_adjust_clears, step && res.adjust |=> !pair_valid && !send_valid)
  `TWCOS_ASSERT(a_send_latch, step && item.cmd == CMD_SEND && pair_valid && !send_valid |=> send_valid && send_local == $past(item.local_now))

endmodule

>>> tb/two_way_clock_offset_sync_test.sv
// testbench for two_way_clock_offset_sync: directed table, random exchanges, scoreboard
`timescale 1ns / 100ps
module two_way_clock_offset_sync_test;
  import twcos_pkg::*;

  typedef struct packed {
    logic              adjust;
    logic [TIME_W-1:0] corrected;
    logic [TIME_W-1:0] offset;
  } fix_t;

  typedef struct {
    item_t stim;
    bit    typed;
    fix_t  want;
  } dir_row_t;

  localparam fix_t NO_FIX = '0;
  localparam int STALL_LIMIT = 800;
  localparam int HOLD_CYCLES = 200;
  localparam int HOLD_AFTER = 300;
  localparam int CALM_AFTER = 940;
  localparam int NUM_PHASES = 5;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [135:0]         s_tdata;   // src_node, remote_time, local_now
  logic                 s_tuser;   // cmd
  logic                 m_tvalid;
  logic                 m_tready;
  logic [127:0]         m_tdata;   // corrected_time, clock_offset
  logic                 m_tuser;   // adjust_valid
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0]     cfg_wdata;

  two_way_clock_offset_sync dut (.*);

  // predictor copy of configuration and exchange state
  logic [GAP_W-1:0]  gap_limit;
  logic [NODE_W-1:0] server_id;
  logic [TIME_W-1:0] pair_remote, pair_local, send_stamp, prev_server_time;
  logic              have_pair, have_send;

  fix_t     pending_fixes[$];
  dir_row_t dir_rows[$];
  int       errors;
  int       sent_count;
  int       idle_cycles;
  bit       calm;
  fix_t     seen_fix;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [TIME_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return rand64();
  endfunction

  function automatic void clear_exchange();
    pair_remote = '0;
    pair_local = '0;
    send_stamp = '0;
    have_pair = 1'b0;
    have_send = 1'b0;
  endfunction

  function automatic fix_t advance_exchange(item_t it);
    fix_t res;
    logic [TIME_W-1:0] d1, d2, pd;
    res = NO_FIX;
    if (it.cmd == CMD_SEND) begin
      if (have_pair && !have_send) begin
        send_stamp = it.local_now;
        have_send = 1'b1;
      end
      return res;
    end
    if (it.src_node != server_id) return res;
    if (it.remote_time - prev_server_time < {32'd0, gap_limit}) begin
      if (!have_pair) begin
        pair_local = it.local_now;
        pair_remote = it.remote_time;
        have_pair = 1'b1;
      end else if (have_send) begin
        d1 = pair_local - pair_remote;
        d2 = it.remote_time - send_stamp;
        pd = (d1 + d2) >> 1;
        res.adjust = 1'b1;
        res.offset = d1 - pd;
        res.corrected = it.local_now - res.offset;
        clear_exchange();
      end
    end else begin
      clear_exchange();
    end
    prev_server_time = it.remote_time;
    return res;
  endfunction

  function automatic item_t next_random_item();
    item_t it;
    int r;
    r = $urandom_range(0, 99);
    it.cmd = CMD_RECV;
    it.src_node = server_id;
    it.remote_time = rand64();
    it.local_now = pick_time();
    if (r < 80) begin
      if (have_send || !have_pair) begin
        if (gap_limit != 0)
          it.remote_time = prev_server_time + ({32'd0, $urandom} % {32'd0, gap_limit});
      end else begin
        it.cmd = CMD_SEND;
        it.src_node = NODE_W'($urandom);
      end
    end else if (r < 86) begin
      it.src_node = server_id + NODE_W'($urandom_range(1, 255));
    end else if (r < 92) begin
      it.remote_time = prev_server_time + {32'd0, gap_limit} + {32'd0, $urandom};
    end else if (r < 96) begin
      it.cmd = CMD_SEND;
      it.src_node = NODE_W'($urandom);
    end else begin
      it.cmd = cmd_t'($urandom_range(0, 1));
      it.src_node = NODE_W'($urandom);
    end
    return it;
  endfunction

  task automatic add_row(input cmd_t c, input logic [NODE_W-1:0] src,
                         input logic [TIME_W-1:0] rt, input logic [TIME_W-1:0] now,
                         input bit typed, input fix_t want);
    dir_row_t row;
    row.stim.cmd = c;
    row.stim.src_node = src;
    row.stim.remote_time = rt;
    row.stim.local_now = now;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  // drive one item, with an optional gap first, and wait for its transaction
  task automatic offer_item(input item_t it, input bit typed, input fix_t want);
    fix_t predicted;
    if (!calm && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 17)) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= it.cmd;
    s_tdata <= {it.local_now, it.remote_time, it.src_node};
    do @(posedge clk); while (!s_tready);
    predicted = advance_exchange(it);
    pending_fixes.push_back(typed ? want : predicted);
    sent_count++;
    if (sent_count >= CALM_AFTER) calm = 1'b1;
  endtask

  task automatic stop_and_drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_fixes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    if (addr == CFG_MAX_GAP) gap_limit = data;
    else server_id = data[NODE_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: random stalls, one long hold-off, none near the end
  initial begin
    bit held;
    held = 1'b0;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      if (!calm && !held && sent_count >= HOLD_AFTER) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          m_tready <= 1'b0;
        end
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 17)) begin
          @(negedge clk);
          m_tready <= 1'b0;
        end
      end else begin
        @(negedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_fixes.size() == 0) begin
        $error("unexpected result transaction: adjust_valid %b", m_tuser);
        errors++;
      end else begin
        seen_fix = pending_fixes.pop_front();
        if (m_tuser !== seen_fix.adjust) begin
          $error("adjust_valid: expected %b, got %b", seen_fix.adjust, m_tuser);
          errors++;
        end
        if (m_tdata[63:0] !== seen_fix.corrected) begin
          $error("corrected_time: expected %h, got %h", seen_fix.corrected, m_tdata[63:0]);
          errors++;
        end
        if (m_tdata[127:64] !== seen_fix.offset) begin
          $error("clock_offset: expected %h, got %h", seen_fix.offset, m_tdata[127:64]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("two_way_clock_offset_sync regression: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [GAP_W-1:0]  phase_gap[NUM_PHASES];
    logic [NODE_W-1:0] phase_node[NUM_PHASES];
    int                phase_items[NUM_PHASES];
    item_t             it;
    errors = 0;
    sent_count = 0;
    calm = 1'b0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= CFG_MAX_GAP;
    cfg_wdata <= '0;
    gap_limit = MAX_GAP_RST;
    server_id = SERVER_NODE_RST;
    clear_exchange();
    prev_server_time = '0;

    phase_gap[0] = '1;          phase_node[0] = '1;      phase_items[0] = 240;
    phase_gap[1] = '0;          phase_node[1] = '0;      phase_items[1] = 80;
    phase_gap[2] = 32'd1;       phase_node[2] = 8'h55;   phase_items[2] = 240;
    phase_gap[3] = $urandom;    phase_node[3] = NODE_W'($urandom); phase_items[3] = 240;
    phase_gap[4] = MAX_GAP_RST; phase_node[4] = SERVER_NODE_RST; phase_items[4] = 240;

    add_row(CMD_SEND, 8'hFF, '1, '1, 1'b1, NO_FIX);
    add_row(CMD_RECV, 8'd7, 64'd100, 64'd0, 1'b1, NO_FIX);
    add_row(CMD_RECV, 8'd8, 64'd0, 64'd0, 1'b1, NO_FIX);
    add_row(CMD_RECV, 8'd8, 64'd10, 64'd5, 1'b1, NO_FIX);
    add_row(CMD_SEND, 8'd8, 64'd0, 64'd20, 1'b1, NO_FIX);
    add_row(CMD_SEND, 8'd0, 64'd123, 64'd999, 1'b1, NO_FIX);
    add_row(CMD_RECV, 8'd9, 64'd30, 64'd40, 1'b1, NO_FIX);
    add_row(CMD_RECV, 8'd8, 64'd30, 64'd40, 1'b1, '{1'b1, 64'd45, 64'hFFFF_FFFF_FFFF_FFFB});
    add_row(CMD_RECV, 8'd8, 64'd2000030, 64'd7, 1'b1, NO_FIX);
    add_row(CMD_RECV, 8'd8, '1, 64'd0, 1'b1, NO_FIX);
    add_row(CMD_RECV, 8'd8, 64'd0, '1, 1'b1, NO_FIX);
    add_row(CMD_SEND, 8'd0, 64'd0, 64'd0, 1'b1, NO_FIX);
    add_row(CMD_RECV, 8'd8, 64'd5, 64'h8000_0000_0000_0000, 1'b0, NO_FIX);
    add_row(CMD_RECV, 8'd8, 64'd2000004, 64'h0123_4567_89AB_CDEF, 1'b0, NO_FIX);
    add_row(CMD_SEND, 8'h55, 64'hDEAD_BEEF_0BAD_F00D, 64'hFFFF_FFFF_0000_0000, 1'b0, NO_FIX);
    add_row(CMD_RECV, 8'd8, 64'd4000003, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, NO_FIX);
    add_row(CMD_RECV, 8'd8, 64'd4000003, 64'd1, 1'b0, NO_FIX);
    add_row(CMD_RECV, 8'd8, 64'd4000004, 64'd2, 1'b0, NO_FIX);
    add_row(CMD_SEND, 8'd8, 64'd0, 64'd3, 1'b0, NO_FIX);
    add_row(CMD_RECV, 8'd8, 64'd6000004, 64'd4, 1'b1, NO_FIX);
    add_row(CMD_RECV, 8'd8, 64'd6000005, 64'hAAAA_5555_AAAA_5555, 1'b0, NO_FIX);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) offer_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    stop_and_drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_MAX_GAP, phase_gap[p]);
      write_reg(CFG_SERVER_NODE,
                {(CFG_W-NODE_W)'($urandom_range(0, 2**(CFG_W-NODE_W)-1)), phase_node[p]});
      for (int n = 0; n < phase_items[p]; n++) begin
        it = next_random_item();
        offer_item(it, 1'b0, NO_FIX);
      end
      stop_and_drain();
    end

    if (errors == 0) begin
      $display("two_way_clock_offset_sync regression: pass");
    end else begin
      $display("two_way_clock_offset_sync regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/twcos_pkg.sv
rtl/twcos_exchange.sv
rtl/two_way_clock_offset_sync.sv
tb/two_way_clock_offset_sync_test.sv
